[hw/rtl/mrtu_pkg.sv]
// ----------------------------------------------------------------------------
// mrtu_pkg
// Shared types and constants of the Modbus RTU input poll master.
// ----------------------------------------------------------------------------
`default_nettype none

package mrtu_pkg;

  // Register indexes of the configuration port
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_CHANNEL_COUNT  = 1'b1;

  localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd1;
  localparam logic [4:0] CHANNEL_COUNT_RESET  = 5'd8;

  localparam int DEF_MAX_CHANNELS = 16;

  // Input opcodes
  localparam logic [1:0] OP_POLL = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;
  localparam logic [1:0] OP_FAIL = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_READING = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;
  localparam logic [1:0] KIND_SETUP   = 2'd3;

  // CRC-16, reflected
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Request frame contents
  localparam logic [7:0] FN_READ_INPUT   = 8'h04;
  localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] SETUP_REG_HI    = 8'h9C;
  localparam logic [7:0] SETUP_REG_LO    = 8'hB9;
  localparam logic [7:0] SETUP_VALUE     = 8'h03;
  localparam logic [7:0] INPUT_REG_HI    = 8'h75;
  localparam logic [7:0] INPUT_REG_LO    = 8'h95;

  localparam logic [5:0]  RX_LIMIT  = 6'd63;
  localparam logic [15:0] CNT_LIMIT = 16'hFFFF;

  typedef struct packed {
    logic init;
    logic load;
    logic shift;
  } crc_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/modbus_rtu_input_poll_master.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_input_poll_master
// Modbus RTU master for an analog input card: builds request frames, parses
// replies and reports channel readings and errors.
//
// Input stream: tuser carries the opcode (poll, reply byte, end of reply,
// failure), tdata the reply byte. Output stream: one transfer per result,
// tuser the kind, tlast on the final result of an item, tdata the byte,
// channel, reading and both saturating frame counters.
// A poll runs the request bytes through a bit-serial CRC unit before the
// first of the 8 frame bytes leaves, then one byte per cycle while the
// receiver takes them. A reply byte gives no result. End of reply and
// failure give one result; an accepted reply gives one reading per channel
// from the value store, each read through its single read port before it
// leaves. Input is taken only while no item is at work; the last result may
// still wait in the output register.
// Reset clears the counters, the setup flag and the reply parser; the
// configuration registers return to address 1 and 8 channels. When the
// receiver stalls, the result holds in the output register and the
// sequencer waits.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_input_poll_master
  import mrtu_pkg::*;
#(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [7:0] tx_byte, [11:8] channel_index,
                                           // [27:12] reading, [43:28] sent_frames,
                                           // [59:44] failed_frames, [63:60] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast
);

  localparam int SW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CRCX = 3'd1;
  localparam logic [2:0] S_CRCS = 3'd2;
  localparam logic [2:0] S_TX   = 3'd3;
  localparam logic [2:0] S_ONE  = 3'd4;
  localparam logic [2:0] S_RDA  = 3'd5;
  localparam logic [2:0] S_RDO  = 3'd6;

  logic [2:0]  state;
  logic [7:0]  device_address;
  logic [4:0]  channel_count;
  logic        setup_done;
  logic [5:0]  rx_count;
  logic        header_ok;
  logic [7:0]  high_hold;
  logic [15:0] sent_total;
  logic [15:0] fail_total;
  logic [2:0]  byte_idx;
  logic [2:0]  bit_cnt;
  logic [4:0]  rd_idx;
  logic [1:0]  one_kind;

  logic [15:0] store [MAX_CHANNELS];
  logic [15:0] rd_data;

  logic [1:0]  o_kind;
  logic [7:0]  o_tx;
  logic [3:0]  o_ch;
  logic [15:0] o_rd;
  logic        o_last;
  logic [15:0] o_sent;
  logic [15:0] o_fail;

  crc_ctl_t    crc_ctl;
  logic [15:0] crc;
  logic [7:0]  frame_byte;

  logic        s_fire;
  logic        out_free;
  logic        emit;
  logic [5:0]  d_pos;
  logic [4:0]  d_ch;
  logic        store_we;
  logic        reply_bad;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = out_free && ((state == S_TX) || (state == S_ONE) || (state == S_RDO));

  assign m_axis_tdata = {4'h0, o_fail, o_sent, o_rd, o_ch, o_tx};
  assign m_axis_tuser = o_kind;
  assign m_axis_tlast = o_last;

  assign d_pos    = rx_count - 6'd3;
  assign d_ch     = d_pos[5:1];
  assign store_we = s_fire && (s_axis_tuser == OP_BYTE) && (rx_count >= 6'd3) &&
                    (rx_count != RX_LIMIT) && d_pos[0] && (int'(d_ch) < MAX_CHANNELS);

  assign reply_bad = (channel_count == 5'd0) || (int'(channel_count) > MAX_CHANNELS) ||
                     !header_ok ||
                     ({1'b0, rx_count} != (7'd5 + {1'b0, channel_count, 1'b0}));

  always_comb begin
    case (byte_idx)
      3'd0:    frame_byte = device_address;
      3'd1:    frame_byte = setup_done ? FN_READ_INPUT : FN_WRITE_SINGLE;
      3'd2:    frame_byte = setup_done ? INPUT_REG_HI : SETUP_REG_HI;
      3'd3:    frame_byte = setup_done ? INPUT_REG_LO : SETUP_REG_LO;
      3'd4:    frame_byte = 8'h00;
      3'd5:    frame_byte = setup_done ? {3'b000, channel_count} : SETUP_VALUE;
      3'd6:    frame_byte = crc[7:0];
      default: frame_byte = crc[15:8];
    endcase
  end

  always_comb begin
    crc_ctl.init  = s_fire && (s_axis_tuser == OP_POLL);
    crc_ctl.load  = (state == S_CRCX);
    crc_ctl.shift = (state == S_CRCS);
  end

  mrtu_crc u_crc (
    .clk  (clk),
    .ctl  (crc_ctl),
    .data (frame_byte),
    .crc  (crc)
  );

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[SW'(d_ch)] <= {high_hold, s_axis_tdata};
    end
    rd_data <= store[SW'(rd_idx)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RESET;
      channel_count  <= CHANNEL_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS: device_address <= cfg_data;
        REG_CHANNEL_COUNT:  channel_count  <= cfg_data[4:0];
        default:            device_address <= device_address;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      setup_done    <= 1'b0;
      rx_count      <= 6'd0;
      header_ok     <= 1'b1;
      high_hold     <= 8'h00;
      sent_total    <= 16'd0;
      fail_total    <= 16'd0;
      byte_idx      <= 3'd0;
      bit_cnt       <= 3'd0;
      rd_idx        <= 5'd0;
      one_kind      <= KIND_ERROR;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            case (s_axis_tuser)
              OP_POLL: begin
                if (sent_total != CNT_LIMIT) begin
                  sent_total <= sent_total + 16'd1;
                end
                rx_count  <= 6'd0;
                header_ok <= 1'b1;
                byte_idx  <= 3'd0;
                bit_cnt   <= 3'd0;
                state     <= S_CRCX;
              end
              OP_BYTE: begin
                if ((rx_count == 6'd0) && (s_axis_tdata != device_address)) begin
                  header_ok <= 1'b0;
                end else if ((rx_count == 6'd1) && (s_axis_tdata != FN_READ_INPUT)) begin
                  header_ok <= 1'b0;
                end else if ((rx_count == 6'd2) &&
                             (s_axis_tdata != {2'b00, channel_count, 1'b0})) begin
                  header_ok <= 1'b0;
                end else if ((rx_count >= 6'd3) && (rx_count != RX_LIMIT) && !d_pos[0]) begin
                  high_hold <= s_axis_tdata;
                end
                if (rx_count != RX_LIMIT) begin
                  rx_count <= rx_count + 6'd1;
                end
              end
              OP_END: begin
                rx_count  <= 6'd0;
                header_ok <= 1'b1;
                if (!setup_done) begin
                  setup_done <= 1'b1;
                  one_kind   <= KIND_SETUP;
                  state      <= S_ONE;
                end else if (reply_bad) begin
                  if (fail_total != CNT_LIMIT) begin
                    fail_total <= fail_total + 16'd1;
                  end
                  one_kind <= KIND_ERROR;
                  state    <= S_ONE;
                end else begin
                  rd_idx <= 5'd0;
                  state  <= S_RDA;
                end
              end
              default: begin
                if (fail_total != CNT_LIMIT) begin
                  fail_total <= fail_total + 16'd1;
                end
                rx_count  <= 6'd0;
                header_ok <= 1'b1;
                one_kind  <= KIND_ERROR;
                state     <= S_ONE;
              end
            endcase
          end
        end
        S_CRCX: begin
          state <= S_CRCS;
        end
        S_CRCS: begin
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            if (byte_idx == 3'd5) begin
              byte_idx <= 3'd0;
              state    <= S_TX;
            end else begin
              byte_idx <= byte_idx + 3'd1;
              state    <= S_CRCX;
            end
          end
        end
        S_TX: begin
          if (out_free) begin
            byte_idx <= byte_idx + 3'd1;
            if (byte_idx == 3'd7) begin
              state <= S_IDLE;
            end
          end
        end
        S_ONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_RDA: begin
          state <= S_RDO;
        end
        S_RDO: begin
          if (out_free) begin
            rd_idx <= rd_idx + 5'd1;
            state  <= ((rd_idx + 5'd1) == channel_count) ? S_IDLE : S_RDA;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload: load when the sequencer hands over a result
  always_ff @(posedge clk) begin
    if (out_free && (state == S_TX)) begin
      o_kind <= KIND_TX;
      o_tx   <= frame_byte;
      o_ch   <= 4'd0;
      o_rd   <= 16'd0;
      o_last <= (byte_idx == 3'd7);
      o_sent <= sent_total;
      o_fail <= fail_total;
    end else if (out_free && (state == S_ONE)) begin
      o_kind <= one_kind;
      o_tx   <= 8'h00;
      o_ch   <= 4'd0;
      o_rd   <= 16'd0;
      o_last <= 1'b1;
      o_sent <= sent_total;
      o_fail <= fail_total;
    end else if (out_free && (state == S_RDO)) begin
      o_kind <= KIND_READING;
      o_tx   <= 8'h00;
      o_ch   <= rd_idx[3:0];
      o_rd   <= rd_data;
      o_last <= ((rd_idx + 5'd1) == channel_count);
      o_sent <= sent_total;
      o_fail <= fail_total;
    end
  end

  a_poll_starts_crc : assert property (@(posedge clk) disable iff (rst)
    s_fire && (s_axis_tuser == OP_POLL) |=> (state == S_CRCX))
    else $error("poll did not start the CRC sequence");

  a_sent_monotonic : assert property (@(posedge clk) disable iff (rst)
    !rst |=> (sent_total >= $past(sent_total)))
    else $error("sent frame counter went down");

  a_last_reading : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (o_kind == KIND_READING) && o_last |->
      (({1'b0, o_ch} + 5'd1) == channel_count))
    else $error("last reading is not the final channel");

  a_busy_not_ready : assert property (@(posedge clk) disable iff (rst)
    (state == S_CRCS) || (state == S_TX) || (state == S_RDO) |-> !s_axis_tready)
    else $error("input taken while an item is at work");

endmodule

`default_nettype wire

[hw/rtl/mrtu_crc.sv]
// ----------------------------------------------------------------------------
// mrtu_crc
// Bit-serial CRC-16 unit: seed, fold in one byte, then one shift per cycle while shift is held.
// ----------------------------------------------------------------------------
`default_nettype none

module mrtu_crc
  import mrtu_pkg::*;
(
  input  wire logic       clk,
  input  wire crc_ctl_t   ctl,
  input  wire logic [7:0] data,
  output logic [15:0]     crc
);

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      crc <= CRC_SEED;
    end else if (ctl.load) begin
      crc <= crc ^ {8'h00, data};
    end else if (ctl.shift) begin
      crc <= crc[0] ? ({1'b0, crc[15:1]} ^ CRC_POLY) : {1'b0, crc[15:1]};
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb_modbus_rtu_input_poll_master.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_input_poll_master
// Self-checking bench for the Modbus RTU input poll master. A directed table
// covers setup, the first read, header and length errors and the channel
// count extremes. Random phases follow, each with new register values: mostly
// well-formed polls and replies, some corrupted, with idle gaps on both
// streams. Every result transfer is checked against a cycle-free model of the
// frame builder, reply parser and counters.
// ----------------------------------------------------------------------------

module tb_modbus_rtu_input_poll_master;
  import mrtu_pkg::*;

  localparam int MAX_CH     = DEF_MAX_CHANNELS;
  localparam int SETTLE     = 20;
  localparam int DRAIN      = 100;
  localparam int HOLD       = 300;
  localparam int RAND_ITEMS = 25;
  localparam int LIMIT      = 1000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [3:0]  chan;
    logic [15:0] value;
    logic        last;
    logic [15:0] sent;
    logic [15:0] failed;
  } result_t;

  typedef struct packed {
    bit         is_cfg;
    logic       idx;
    logic [1:0] op;
    logic [7:0] data;
    bit         known;
    result_t    want;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic [1:0]  s_axis_tuser = 2'b00;   // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;           // [7:0] tx_byte, [11:8] channel_index,
                                       // [27:12] reading, [43:28] sent_frames,
                                       // [59:44] failed_frames
  logic [1:0]  m_axis_tuser;           // [1:0] kind
  logic        m_axis_tlast;

  // poll master state as seen from outside
  logic [7:0]  pm_addr;
  logic [4:0]  pm_count;
  logic        pm_setup;
  logic [5:0]  pm_rx;
  logic        pm_hdr_ok;
  logic [7:0]  pm_high;
  logic [15:0] pm_store [MAX_CH];
  logic [15:0] pm_sent;
  logic [15:0] pm_fail;

  result_t     due_results [$];
  result_t     head;
  row_t        plan [$];
  logic [7:0]  burst [$];
  int          errors;
  int          fed;
  int          hold_off;
  int          rx_gap;
  bit          calm;

  modbus_rtu_input_poll_master dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return 0;
    if (r < 98) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] data_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic result_t mk_result(input logic [1:0] kind, input logic [7:0] tx,
                                        input logic [3:0] chan, input logic [15:0] value,
                                        input logic last);
    result_t res;
    res.kind   = kind;
    res.tx     = tx;
    res.chan   = chan;
    res.value  = value;
    res.last   = last;
    res.sent   = pm_sent;
    res.failed = pm_fail;
    return res;
  endfunction

  function automatic row_t op_row(input logic [1:0] op, input logic [7:0] data);
    row_t row;
    row        = '0;
    row.op     = op;
    row.data   = data;
    return row;
  endfunction

  function automatic row_t cfg_row(input logic idx, input logic [7:0] data);
    row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    return row;
  endfunction

  function automatic row_t known_row(input logic [1:0] op, input logic [1:0] kind,
                                     input logic [15:0] value, input logic [15:0] sent,
                                     input logic [15:0] failed);
    row_t row;
    row             = '0;
    row.op          = op;
    row.data        = 8'hFF;
    row.known       = 1'b1;
    row.want.kind   = kind;
    row.want.value  = value;
    row.want.last   = 1'b1;
    row.want.sent   = sent;
    row.want.failed = failed;
    return row;
  endfunction

  task automatic step_master(input logic [1:0] op, input logic [7:0] b);
    logic [7:0]  frame [8];
    logic [15:0] crc;
    logic [5:0]  pos;
    case (op)
      OP_POLL: begin
        frame[0] = pm_addr;
        if (!pm_setup) begin
          frame[1] = FN_WRITE_SINGLE;
          frame[2] = SETUP_REG_HI;
          frame[3] = SETUP_REG_LO;
          frame[4] = 8'h00;
          frame[5] = SETUP_VALUE;
        end else begin
          frame[1] = FN_READ_INPUT;
          frame[2] = INPUT_REG_HI;
          frame[3] = INPUT_REG_LO;
          frame[4] = 8'h00;
          frame[5] = {3'b000, pm_count};
        end
        crc = CRC_SEED;
        for (int i = 0; i < 6; i++) crc = crc16_byte(crc, frame[i]);
        frame[6] = crc[7:0];
        frame[7] = crc[15:8];
        if (pm_sent != CNT_LIMIT) pm_sent++;
        for (int i = 0; i < 8; i++)
          due_results.push_back(mk_result(KIND_TX, frame[i], 4'd0, 16'h0000, i == 7));
      end
      OP_BYTE: begin
        if (pm_rx == 6'd0) begin
          if (b != pm_addr) pm_hdr_ok = 1'b0;
        end else if (pm_rx == 6'd1) begin
          if (b != FN_READ_INPUT) pm_hdr_ok = 1'b0;
        end else if (pm_rx == 6'd2) begin
          if (b != {2'b00, pm_count, 1'b0}) pm_hdr_ok = 1'b0;
        end else if (pm_rx != RX_LIMIT) begin
          pos = pm_rx - 6'd3;
          if (!pos[0]) pm_high = b;
          else if (pos[5:1] < MAX_CH) pm_store[pos[4:1]] = {pm_high, b};
        end
        if (pm_rx != RX_LIMIT) pm_rx++;
      end
      OP_END: begin
        if (!pm_setup) begin
          pm_setup = 1'b1;
          due_results.push_back(mk_result(KIND_SETUP, 8'h00, 4'd0, 16'h0000, 1'b1));
        end else if (pm_count == 5'd0 || pm_count > MAX_CH || !pm_hdr_ok
                     || int'(pm_rx) != 5 + 2 * int'(pm_count)) begin
          if (pm_fail != CNT_LIMIT) pm_fail++;
          due_results.push_back(mk_result(KIND_ERROR, 8'h00, 4'd0, 16'h0000, 1'b1));
        end else begin
          for (int i = 0; i < int'(pm_count); i++)
            due_results.push_back(mk_result(KIND_READING, 8'h00, 4'(i), pm_store[i],
                                            i == int'(pm_count) - 1));
        end
      end
      default: begin
        if (pm_fail != CNT_LIMIT) pm_fail++;
        due_results.push_back(mk_result(KIND_ERROR, 8'h00, 4'd0, 16'h0000, 1'b1));
      end
    endcase
    if (op != OP_BYTE) begin
      pm_rx     = '0;
      pm_hdr_ok = 1'b1;
    end
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] data);
    int gap;
    gap = calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    step_master(op, data);
    fed++;
  endtask

  // drop valid and hold until every due result has arrived
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DEVICE_ADDRESS) pm_addr = val;
    else pm_count = val[4:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      m_axis_tready <= 1'b0;
      hold_off--;
    end else if (rx_gap > 0) begin
      m_axis_tready <= 1'b0;
      rx_gap--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm) rx_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        report("result with none due", m_axis_tdata[31:0], 32'h0);
      end else begin
        head = due_results.pop_front();
        if (m_axis_tuser !== head.kind)
          report("kind", 32'(m_axis_tuser), 32'(head.kind));
        if (m_axis_tdata[7:0] !== head.tx)
          report("tx_byte", 32'(m_axis_tdata[7:0]), 32'(head.tx));
        if (m_axis_tdata[11:8] !== head.chan)
          report("channel_index", 32'(m_axis_tdata[11:8]), 32'(head.chan));
        if (m_axis_tdata[27:12] !== head.value)
          report("reading", 32'(m_axis_tdata[27:12]), 32'(head.value));
        if (m_axis_tdata[43:28] !== head.sent)
          report("sent_frames", 32'(m_axis_tdata[43:28]), 32'(head.sent));
        if (m_axis_tdata[59:44] !== head.failed)
          report("failed_frames", 32'(m_axis_tdata[59:44]), 32'(head.failed));
        if (m_axis_tlast !== head.last)
          report("tlast", 32'(m_axis_tlast), 32'(head.last));
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("tb_modbus_rtu_input_poll_master: done, errors");
    $finish;
  end

  initial begin
    int         base;
    int         r;
    bit         first;
    logic [1:0] closer;
    logic [4:0] cnt;

    errors    = 0;
    fed       = 0;
    hold_off  = 0;
    rx_gap    = 0;
    calm      = 1'b0;
    pm_addr   = DEVICE_ADDRESS_RESET;
    pm_count  = CHANNEL_COUNT_RESET;
    pm_setup  = 1'b0;
    pm_rx     = '0;
    pm_hdr_ok = 1'b1;
    pm_high   = 8'h00;
    pm_sent   = '0;
    pm_fail   = '0;
    for (int i = 0; i < MAX_CH; i++) pm_store[i] = 16'h0000;

    plan.push_back(op_row(OP_POLL, 8'h00));
    plan.push_back(known_row(OP_FAIL, KIND_ERROR, 16'h0000, 16'd1, 16'd1));
    plan.push_back(known_row(OP_END, KIND_SETUP, 16'h0000, 16'd1, 16'd1));
    plan.push_back(known_row(OP_END, KIND_ERROR, 16'h0000, 16'd1, 16'd2));
    plan.push_back(cfg_row(REG_CHANNEL_COUNT, 8'd1));
    plan.push_back(cfg_row(REG_DEVICE_ADDRESS, 8'hFF));
    plan.push_back(op_row(OP_POLL, 8'hFF));
    plan.push_back(op_row(OP_BYTE, 8'hFF));
    plan.push_back(op_row(OP_BYTE, FN_READ_INPUT));
    plan.push_back(op_row(OP_BYTE, 8'h02));
    plan.push_back(op_row(OP_BYTE, 8'hFF));
    plan.push_back(op_row(OP_BYTE, 8'hFF));
    plan.push_back(op_row(OP_BYTE, 8'hA5));
    plan.push_back(op_row(OP_BYTE, 8'h5A));
    plan.push_back(known_row(OP_END, KIND_READING, 16'hFFFF, 16'd2, 16'd2));
    plan.push_back(cfg_row(REG_DEVICE_ADDRESS, 8'h00));
    plan.push_back(cfg_row(REG_CHANNEL_COUNT, 8'd16));
    plan.push_back(op_row(OP_POLL, 8'h00));
    plan.push_back(op_row(OP_BYTE, 8'h00));
    plan.push_back(op_row(OP_BYTE, FN_WRITE_SINGLE));
    plan.push_back(op_row(OP_BYTE, 8'h20));
    plan.push_back(known_row(OP_END, KIND_ERROR, 16'h0000, 16'd3, 16'd3));
    plan.push_back(cfg_row(REG_CHANNEL_COUNT, 8'hE0));
    plan.push_back(op_row(OP_POLL, 8'h55));
    plan.push_back(known_row(OP_END, KIND_ERROR, 16'h0000, 16'd4, 16'd4));

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].op, plan[i].data);
        if (plan[i].known) begin
          void'(due_results.pop_back());
          due_results.push_back(plan[i].want);
        end
      end
    end

    // overlong reply: saturate the byte count
    wait_idle();
    write_reg(REG_CHANNEL_COUNT, 8'd2);
    send_item(OP_POLL, 8'($urandom));
    send_item(OP_BYTE, pm_addr);
    send_item(OP_BYTE, FN_READ_INPUT);
    send_item(OP_BYTE, 8'd4);
    repeat (64) send_item(OP_BYTE, data_byte());
    send_item(OP_END, 8'($urandom));

    base  = fed;
    first = 1'b1;
    while (fed - base < RAND_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0:       write_reg(REG_DEVICE_ADDRESS, 8'h00);
        1:       write_reg(REG_DEVICE_ADDRESS, 8'hFF);
        default: write_reg(REG_DEVICE_ADDRESS, 8'($urandom));
      endcase
      r = $urandom_range(0, 19);
      if (r < 12) cnt = 5'($urandom_range(1, 4));
      else if (r < 14) cnt = 5'd16;
      else if (r < 16) cnt = 5'($urandom_range(1, 16));
      else if (r < 18) cnt = 5'd0;
      else cnt = $urandom_range(0, 1) ? 5'd31 : 5'($urandom_range(17, 31));
      write_reg(REG_CHANNEL_COUNT, {3'($urandom), cnt});
      calm = ($urandom_range(0, 3) == 0);
      if (first) hold_off = HOLD;
      first = 1'b0;

      repeat ($urandom_range(2, 4)) begin
        r = $urandom_range(0, 99);
        burst.delete();
        burst.push_back(pm_addr);
        burst.push_back(FN_READ_INPUT);
        burst.push_back({2'b00, pm_count, 1'b0});
        repeat (2 * int'(pm_count) + 2) burst.push_back(data_byte());
        closer = OP_END;
        if (r >= 65 && r < 85) begin
          case ($urandom_range(0, 3))
            0:       burst[$urandom_range(0, 2)] = 8'($urandom);
            1:       void'(burst.pop_back());
            2:       burst.push_back(8'($urandom));
            default: closer = OP_FAIL;
          endcase
        end else if (r >= 85) begin
          burst.delete();
          repeat ($urandom_range(0, 5)) burst.push_back(8'($urandom));
          closer = $urandom_range(0, 1) ? OP_END : OP_FAIL;
        end
        if (r < 95) send_item(OP_POLL, 8'($urandom));
        foreach (burst[i]) send_item(OP_BYTE, burst[i]);
        send_item(closer, 8'($urandom));
        if ($urandom_range(0, 5) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("tb_modbus_rtu_input_poll_master: done, clean");
    else $display("tb_modbus_rtu_input_poll_master: done, errors");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mrtu_pkg.sv
hw/rtl/mrtu_crc.sv
hw/rtl/modbus_rtu_input_poll_master.sv
tb/sv/tb_modbus_rtu_input_poll_master.sv
